[rtl/sida_pkg.sv]
// Shared types, constants and helpers for the signed integer to decimal text block.
`timescale 1ns / 1ps

package sida_pkg;

	localparam int DATA_W     = 32;
	localparam int NDIG       = 10;
	localparam int DIG_W      = 4;
	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 4;
	localparam int IDX_W      = $clog2(NDIG);
	localparam int BITS_STEP  = 4;
	localparam int N_STEPS    = DATA_W / BITS_STEP;
	localparam int STEP_W     = $clog2(N_STEPS);
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef logic [NDIG-1:0][DIG_W-1:0] bcd_t;

	typedef struct packed {
		logic              neg;
		logic [DATA_W-1:0] mag;
	} item_t;

	typedef struct packed {
		logic             neg;
		bcd_t             bcd;
		logic [LEN_W-1:0] ndig;
	} digits_t;

	function automatic logic [DIG_W-1:0] add3(input logic [DIG_W-1:0] d);
		add3 = (d >= DIG_W'(5)) ? d + DIG_W'(3) : d;
	endfunction

endpackage

[rtl/sida_front.sv]
// Front stage: accepts a value and registers its sign and unsigned magnitude.
`timescale 1ns / 1ps

module sida_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [sida_pkg::DATA_W-1:0]   in_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output sida_pkg::item_t                      out_item
);
	import sida_pkg::*;

	logic  full_q;
	item_t item_q;
	logic  neg;
	logic  in_fire;

	assign in_ready  = !full_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign neg       = in_value[DATA_W-1];
	assign out_valid = full_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_fire) begin
			full_q <= 1'b1;
		end else if (out_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q.neg <= neg;
			item_q.mag <= neg ? DATA_W'(0) - DATA_W'(in_value) : DATA_W'(in_value);
		end
	end

endmodule

[rtl/sida_fifo.sv]
// Short queue between the front stage and the converter.
`timescale 1ns / 1ps

module sida_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sida_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sida_pkg::item_t pop_item
);
	import sida_pkg::*;

	item_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = cnt_q != CNT_W'(FIFO_DEPTH);
	assign pop_valid  = cnt_q != CNT_W'(0);
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/sida_conv.sv]
// Binary to BCD converter: shift and add-three, four bits per cycle.
`timescale 1ns / 1ps

module sida_conv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sida_pkg::item_t   in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output sida_pkg::digits_t out_digits
);
	import sida_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	bcd_t                bcd_q;
	logic [DATA_W-1:0]   sh_q;
	logic                neg_q;
	bcd_t                work;
	logic [DATA_W-1:0]   sh;
	logic [LEN_W-1:0]    ndig;
	logic                in_fire;
	logic                out_fire;
	logic                last_step;

	assign in_ready  = !busy_q && (!done_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = done_q;
	assign out_fire  = done_q && out_ready;
	assign last_step = step_q == STEP_W'(N_STEPS - 1);

	always_comb begin
		work = bcd_q;
		sh   = sh_q;
		for (int b = 0; b < BITS_STEP; b++) begin
			for (int d = 0; d < NDIG; d++) begin
				work[d] = add3(work[d]);
			end
			{work, sh} = {work, sh} << 1;
		end
	end

	always_comb begin
		ndig = LEN_W'(1);
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[d] != '0) begin
				ndig = LEN_W'(d + 1);
			end
		end
	end

	assign out_digits.neg  = neg_q;
	assign out_digits.bcd  = bcd_q;
	assign out_digits.ndig = ndig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (out_fire) begin
				done_q <= 1'b0;
			end
			if (in_fire) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			bcd_q <= '0;
			sh_q  <= in_item.mag;
			neg_q <= in_item.neg;
		end else if (busy_q) begin
			bcd_q <= work;
			sh_q  <= sh;
		end
	end

endmodule

[rtl/sida_emit.sv]
// Character sequencer: sends the sign and the digits, one beat per character.
`timescale 1ns / 1ps

module sida_emit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  sida_pkg::digits_t                    in_digits,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sida_pkg::CHAR_W-1:0]          out_char,
	output logic                                 out_last,
	output logic [sida_pkg::LEN_W-1:0]           out_len
);
	import sida_pkg::*;

	logic              act_q;
	logic              sign_q;
	logic [IDX_W-1:0]  idx_q;
	bcd_t              bcd_q;
	logic [LEN_W-1:0]  len_q;
	logic              ovalid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic [LEN_W-1:0]  olen_q;
	logic              adv;
	logic              final_char;
	logic              in_fire;

	assign adv        = !ovalid_q || out_ready;
	assign final_char = act_q && !sign_q && (idx_q == '0);
	assign in_ready   = !act_q || (adv && final_char);
	assign in_fire    = in_valid && in_ready;

	assign out_valid = ovalid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;
	assign out_len   = olen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			ovalid_q <= 1'b0;
			sign_q   <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (adv) begin
				ovalid_q <= act_q;
			end
			if (in_fire) begin
				act_q  <= 1'b1;
				sign_q <= in_digits.neg;
				idx_q  <= IDX_W'(in_digits.ndig - LEN_W'(1));
			end else if (adv && act_q) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else begin
					idx_q <= idx_q - IDX_W'(1);
					if (idx_q == '0) begin
						act_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && act_q) begin
			olen_q <= len_q;
			if (sign_q) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + CHAR_W'(bcd_q[idx_q]);
				last_q <= idx_q == '0;
			end
		end
		if (in_fire) begin
			bcd_q <= in_digits.bcd;
			len_q <= in_digits.ndig + LEN_W'(in_digits.neg);
		end
	end

endmodule

[rtl/signed_int_to_decimal_ascii_top.sv]
// Top level: signed 32-bit integer to decimal ASCII text, one character per beat.
//
// Channel  Signals                                          Beat
// value    value_valid, value_ready, value                  one signed 32-bit value
// char     char_valid, char_ready, character, last, length  one ASCII character of the text
//
// Each value passes through the shift and add-three converter, which runs
// ahead of the character sequencer. The sequencer sends one character per cycle
// while it holds a value and the output is not stalled. Reset clears all control
// state; no state is kept between values. Either side may stall independently:
// a two-entry queue and the converter's result register absorb the difference.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 value_valid,
	output logic                                 value_ready,
	input  logic signed [sida_pkg::DATA_W-1:0]   value,
	output logic                                 char_valid,
	input  logic                                 char_ready,
	output logic [sida_pkg::CHAR_W-1:0]          character,
	output logic                                 last,
	output logic [sida_pkg::LEN_W-1:0]           length
);
	import sida_pkg::*;

	logic    fr_valid;
	logic    fr_ready;
	item_t   fr_item;
	logic    q_valid;
	logic    q_ready;
	item_t   q_item;
	logic    cv_valid;
	logic    cv_ready;
	digits_t cv_digits;

	sida_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (value_valid),
		.in_ready  (value_ready),
		.in_value  (value),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_item  (fr_item)
	);

	sida_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	sida_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ready   (q_ready),
		.in_item    (q_item),
		.out_valid  (cv_valid),
		.out_ready  (cv_ready),
		.out_digits (cv_digits)
	);

	sida_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cv_valid),
		.in_ready  (cv_ready),
		.in_digits (cv_digits),
		.out_valid (char_valid),
		.out_ready (char_ready),
		.out_char  (character),
		.out_last  (last),
		.out_len   (length)
	);

endmodule

[tb/sv/sida_text_checker.sv]
// Checker that predicts the decimal text of each accepted value and compares every character beat.
`timescale 1ns / 1ps

module sida_text_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              value_valid,
	input  logic                              value_ready,
	input  logic signed [sida_pkg::DATA_W-1:0] value,
	input  logic                              char_valid,
	input  logic                              char_ready,
	input  logic [sida_pkg::CHAR_W-1:0]       character,
	input  logic                              last,
	input  logic [sida_pkg::LEN_W-1:0]        length,
	output int                                fail_count,
	output int                                chars_owed,
	output int                                chars_checked
);

	typedef struct {
		logic [sida_pkg::CHAR_W-1:0] ch;
		logic                        fin;
		logic [sida_pkg::LEN_W-1:0]  len;
	} text_char_t;

	text_char_t owed_text[$];

	initial begin
		fail_count    = 0;
		chars_owed    = 0;
		chars_checked = 0;
	end

	function automatic void spell_value(input logic [sida_pkg::DATA_W-1:0] v);
		logic                         neg;
		logic [sida_pkg::DATA_W-1:0]  mag;
		logic [sida_pkg::DIG_W-1:0]   digs [sida_pkg::NDIG];
		int                           nd;
		logic [sida_pkg::LEN_W-1:0]   total;
		text_char_t                   tc;
		neg = v[sida_pkg::DATA_W-1];
		mag = neg ? (32'd0 - v) : v;
		nd  = 0;
		do begin
			digs[nd] = sida_pkg::DIG_W'(mag % 32'd10);
			mag      = mag / 32'd10;
			nd++;
		end while (mag != 32'd0 && nd < sida_pkg::NDIG);
		total = sida_pkg::LEN_W'(nd + (neg ? 1 : 0));
		if (neg) begin
			tc.ch  = sida_pkg::CHAR_MINUS;
			tc.fin = 1'b0;
			tc.len = total;
			owed_text.push_back(tc);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			tc.ch  = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(digs[i]);
			tc.fin = (i == 0);
			tc.len = total;
			owed_text.push_back(tc);
		end
	endfunction

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (char_valid && char_ready) begin
				chars_checked++;
				if (owed_text.size() == 0) begin
					$display("%0t: unexpected character beat 0x%02h last %0b length %0d",
						$time, character, last, length);
					fail_count++;
				end else begin
					want = owed_text.pop_front();
					if (character !== want.ch) begin
						$display("%0t: character expected 0x%02h actual 0x%02h",
							$time, want.ch, character);
						fail_count++;
					end
					if (last !== want.fin) begin
						$display("%0t: last expected %0b actual %0b", $time, want.fin, last);
						fail_count++;
					end
					if (length !== want.len) begin
						$display("%0t: length expected %0d actual %0d",
							$time, want.len, length);
						fail_count++;
					end
				end
			end
			if (value_valid && value_ready)
				spell_value(value);
			chars_owed = owed_text.size();
		end
	end

endmodule

[tb/sv/tb_signed_int_to_decimal_ascii_top.sv]
// Testbench top: drives values into the converter, paces the character side and gives the verdict.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_top;

	localparam int RANDOM_ITEMS = 157;
	localparam int SQUEEZE_AT   = 60;
	localparam int SQUEEZE_LEN  = 400;

	logic                               clk;
	logic                               arst_n;
	logic                               value_valid;
	logic                               value_ready;
	logic signed [sida_pkg::DATA_W-1:0] value;
	logic                               char_valid;
	logic                               char_ready;
	logic [sida_pkg::CHAR_W-1:0]        character;
	logic                               last;
	logic [sida_pkg::LEN_W-1:0]         length;

	int   fail_count;
	int   chars_owed;
	int   chars_checked;
	int   sent_items;
	int   squeeze_left;
	bit   squeezed;
	logic calm;

	logic [sida_pkg::DATA_W-1:0] corner_vals [$] = '{
		32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6, 32'd99, 32'd100,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
		32'hC465_3601, 32'hC465_3600, 32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789,
		32'hF8A4_32EB, 32'd7, 32'hFFFF_FFF9, 32'd1000000, 32'd2147483640
	};

	assign calm = (sent_items >= 110) && (sent_items < 150);

	signed_int_to_decimal_ascii_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.value       (value),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.character   (character),
		.last        (last),
		.length      (length)
	);

	sida_text_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.value_valid   (value_valid),
		.value_ready   (value_ready),
		.value         (value),
		.char_valid    (char_valid),
		.char_ready    (char_ready),
		.character     (character),
		.last          (last),
		.length        (length),
		.fail_count    (fail_count),
		.chars_owed    (chars_owed),
		.chars_checked (chars_checked)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [sida_pkg::DATA_W-1:0] pick_value();
		longint lo;
		longint hi;
		longint mag;
		int     n;
		if ($urandom_range(3) == 0)
			return $urandom;
		n  = $urandom_range(1, 10);
		lo = 1;
		for (int i = 1; i < n; i++)
			lo = lo * 10;
		hi = lo * 10 - 1;
		if (n == 1)
			lo = 0;
		if (hi > 64'sd2147483647)
			hi = 64'sd2147483647;
		mag = lo + longint'($urandom % (hi - lo + 1));
		if ($urandom_range(1))
			return sida_pkg::DATA_W'(-mag);
		return sida_pkg::DATA_W'(mag);
	endfunction

	task automatic offer(input logic [sida_pkg::DATA_W-1:0] v);
		if (!calm) begin
			while ($urandom_range(99) < 25) begin
				value_valid <= 1'b0;
				@(negedge clk);
			end
		end
		value_valid <= 1'b1;
		value       <= v;
		do @(posedge clk); while (!value_ready);
		sent_items++;
		@(negedge clk);
	endtask

	initial begin
		squeeze_left = 0;
		squeezed     = 1'b0;
		char_ready   = 1'b0;
		forever begin
			@(negedge clk);
			if (!squeezed && sent_items >= SQUEEZE_AT) begin
				squeezed     = 1'b1;
				squeeze_left = SQUEEZE_LEN;
			end
			if (squeeze_left > 0) begin
				char_ready <= 1'b0;
				squeeze_left--;
			end else if (calm) begin
				char_ready <= 1'b1;
			end else begin
				char_ready <= ($urandom_range(99) >= 25);
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		value_valid = 1'b0;
		value       = '0;
		sent_items  = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		foreach (corner_vals[i])
			offer(corner_vals[i]);
		repeat (RANDOM_ITEMS)
			offer(pick_value());
		value_valid <= 1'b0;
		while (chars_owed != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		$display("Run covered %0d values (%0d corner cases, %0d random) and %0d character beats,",
			sent_items, corner_vals.size(), RANDOM_ITEMS, chars_checked);
		$display("with random idling on both sides, a calm stretch and a %0d-cycle output hold.",
			SQUEEZE_LEN);
		if (fail_count == 0 && chars_owed == 0) begin
			$display("signed_int_to_decimal_ascii_top: match");
		end else begin
			$display("signed_int_to_decimal_ascii_top: mismatch");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Run timed out with %0d character beats still owed.", chars_owed);
		$display("signed_int_to_decimal_ascii_top: mismatch");
		$finish;
	end

endmodule
